// ===== rtl/sem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants and types for the 3x3 Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT        = 4096;

  localparam int LINE_WIDTH_W   = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int PIXEL_W        = 8;
  localparam int GRAD_W         = 11;
  localparam int COL_OUT_W      = 10;
  localparam int ROW_W          = 12;

  localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RESET   = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic                 emit;
    logic                 last;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
  } sem_ctrl_t;

endpackage

// ===== rtl/sobel_edge_magnitude_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3
// 3x3 Sobel edge detector with saturated L1 magnitude over a raster pixel
// stream. A result passes the window, gradient and output registers after
// the pixel below-right of its centre is accepted. Throughput: one pixel per
// cycle unless out_stall backs up the pipeline, set by the single read and
// single write port of the row store. Reset clears counters, window taps and
// stage valid bits, loads width 640 and height 480; row store not cleared.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic                     wr_index,
  input  logic [CFG_DATA_W-1:0]    wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PIXEL_W-1:0]       pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PIXEL_W-1:0]       magnitude,
  output logic signed [GRAD_W-1:0] grad_x,
  output logic signed [GRAD_W-1:0] grad_y,
  output logic                     saturated,
  output logic [COL_OUT_W-1:0]     center_column,
  output logic [ROW_W-1:0]         center_row,
  output logic                     last_of_frame
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [LINE_WIDTH_W-1:0]   line_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;
  logic [AW-1:0]             col_count;
  logic [ROW_W-1:0]          row_count;

  logic [WW-1:0]             w_eff;
  logic [FRAME_HEIGHT_W-1:0] h_eff;
  logic [AW-1:0]             c_cur;
  logic [ROW_W-1:0]          r_cur;
  logic [WW-1:0]             c_inc;
  logic [FRAME_HEIGHT_W-1:0] r_inc;
  logic                      col_wrap, row_wrap;
  logic [AW-1:0]             c_m1;
  sem_ctrl_t                 ctrl_in;

  logic                      ready_a, in_fire;
  logic [PIXEL_W-1:0]        rd_top, rd_mid;
  logic                      ls_wr_en;
  logic [AW-1:0]             ls_wr_addr;
  logic [2*PIXEL_W-1:0]      ls_wr_word;
  logic                      b_valid, b_take;
  sem_ctrl_t                 b_ctrl;
  logic signed [GRAD_W-1:0]  b_gx, b_gy;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_LINE_WIDTH:   line_width   <= wr_data[LINE_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= wr_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_width < LINE_WIDTH_W'(3)) begin
      w_eff = WW'(3);
    end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(line_width);
    end
    if (frame_height < FRAME_HEIGHT_W'(3)) begin
      h_eff = FRAME_HEIGHT_W'(3);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_eff = FRAME_HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign c_cur    = (WW'(col_count) >= w_eff) ? '0 : col_count;
  assign r_cur    = (FRAME_HEIGHT_W'(row_count) >= h_eff) ? '0 : row_count;
  assign c_inc    = WW'(c_cur) + WW'(1);
  assign r_inc    = FRAME_HEIGHT_W'(r_cur) + FRAME_HEIGHT_W'(1);
  assign col_wrap = c_inc >= w_eff;
  assign row_wrap = r_inc >= h_eff;
  assign c_m1     = c_cur - AW'(1);

  assign ctrl_in.emit = (r_cur >= ROW_W'(2)) && (c_cur >= AW'(2));
  assign ctrl_in.last = (WW'(c_cur) == w_eff - WW'(1)) &&
                        (FRAME_HEIGHT_W'(r_cur) == h_eff - FRAME_HEIGHT_W'(1));
  assign ctrl_in.col  = COL_OUT_W'(c_m1);
  assign ctrl_in.row  = r_cur - ROW_W'(1);

  assign in_stall = !ready_a;
  assign in_fire  = in_valid && ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : r_inc[ROW_W-1:0];
      end else begin
        col_count <= c_inc[AW-1:0];
        row_count <= r_cur;
      end
    end
  end

  sem_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (c_cur),
    .rd_top  (rd_top),
    .rd_mid  (rd_mid),
    .wr_en   (ls_wr_en),
    .wr_addr (ls_wr_addr),
    .wr_word (ls_wr_word)
  );

  sem_window #(
    .AW (AW)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .pixel_in (pixel),
    .addr_in  (c_cur),
    .ctrl_in  (ctrl_in),
    .ready_a  (ready_a),
    .rd_top   (rd_top),
    .rd_mid   (rd_mid),
    .wr_en    (ls_wr_en),
    .wr_addr  (ls_wr_addr),
    .wr_word  (ls_wr_word),
    .b_valid  (b_valid),
    .b_ctrl   (b_ctrl),
    .b_gx     (b_gx),
    .b_gy     (b_gy),
    .b_take   (b_take)
  );

  sem_magnitude u_magnitude (
    .clk           (clk),
    .rst           (rst),
    .b_valid       (b_valid),
    .b_ctrl        (b_ctrl),
    .b_gx          (b_gx),
    .b_gy          (b_gy),
    .b_take        (b_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .magnitude     (magnitude),
    .grad_x        (grad_x),
    .grad_y        (grad_y),
    .saturated     (saturated),
    .center_column (center_column),
    .center_row    (center_row),
    .last_of_frame (last_of_frame)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  a_sat_magnitude: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (magnitude == 8'd255))
    else $error("saturated result without full-scale magnitude");

  a_interior_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (center_row != '0))
    else $error("result for a border row");

  a_ls_write_follows_read: assert property (@(posedge clk) disable iff (rst)
    (ls_wr_en && in_fire) |-> (ls_wr_addr != c_cur))
    else $error("row store read and write at the same column");

endmodule

// ===== rtl/sem_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_line_store
// Two row stores in one synchronous memory: each word holds the pixel of the
// row two above and of the row above at one column. Registered read.
// ----------------------------------------------------------------------------
module sem_line_store
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [PIXEL_W-1:0]   rd_top,
  output logic [PIXEL_W-1:0]   rd_mid,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [2*PIXEL_W-1:0] wr_word
);

  logic [2*PIXEL_W-1:0] mem [MAX_WIDTH];
  logic [2*PIXEL_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_top = rd_word[2*PIXEL_W-1:PIXEL_W];
  assign rd_mid = rd_word[PIXEL_W-1:0];

endmodule

// ===== rtl/sem_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_window
// Window stage: holds the accepted pixel beside the row store read data,
// forms both gradients from the taps, writes the column back and shifts the
// taps. Gradients of interior centres are registered for the next stage.
// ----------------------------------------------------------------------------
module sem_window
  import sem_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_fire,
  input  logic [PIXEL_W-1:0]       pixel_in,
  input  logic [AW-1:0]            addr_in,
  input  sem_ctrl_t                ctrl_in,
  output logic                     ready_a,
  input  logic [PIXEL_W-1:0]       rd_top,
  input  logic [PIXEL_W-1:0]       rd_mid,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [2*PIXEL_W-1:0]     wr_word,
  output logic                     b_valid,
  output sem_ctrl_t                b_ctrl,
  output logic signed [GRAD_W-1:0] b_gx,
  output logic signed [GRAD_W-1:0] b_gy,
  input  logic                     b_take
);

  logic               a_valid;
  logic [PIXEL_W-1:0] a_pixel;
  logic [AW-1:0]      a_addr;
  sem_ctrl_t          a_ctrl;
  logic [PIXEL_W-1:0] taps [6];
  logic               ready_b;
  logic               fire_a;
  logic [GRAD_W-1:0]  tl, ml, bl, tm, bm, tr, mr, br;
  logic [GRAD_W-1:0]  gx_next, gy_next;

  assign ready_b = !b_valid || b_take;
  assign ready_a = !a_valid || ready_b;
  assign fire_a  = a_valid && ready_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (fire_a) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_pixel <= pixel_in;
      a_addr  <= addr_in;
      a_ctrl  <= ctrl_in;
    end
  end

  assign tl = GRAD_W'(taps[0]);
  assign ml = GRAD_W'(taps[1]);
  assign bl = GRAD_W'(taps[2]);
  assign tm = GRAD_W'(taps[3]);
  assign bm = GRAD_W'(taps[5]);
  assign tr = GRAD_W'(rd_top);
  assign mr = GRAD_W'(rd_mid);
  assign br = GRAD_W'(a_pixel);

  assign gx_next = (tr + (mr << 1) + br) - (tl + (ml << 1) + bl);
  assign gy_next = (tl + (tm << 1) + tr) - (bl + (bm << 1) + br);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        taps[i] <= '0;
      end
    end else if (fire_a) begin
      taps[0] <= taps[3];
      taps[1] <= taps[4];
      taps[2] <= taps[5];
      taps[3] <= rd_top;
      taps[4] <= rd_mid;
      taps[5] <= a_pixel;
    end
  end

  assign wr_en   = fire_a;
  assign wr_addr = a_addr;
  assign wr_word = {rd_mid, a_pixel};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (fire_a) begin
      b_valid <= a_ctrl.emit;
    end else if (b_take) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_a) begin
      b_ctrl <= a_ctrl;
      b_gx   <= gx_next;
      b_gy   <= gy_next;
    end
  end

endmodule

// ===== rtl/sem_magnitude.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_magnitude
// Output stage: L1 magnitude of the gradients, saturated at 255, held in the
// output register until taken.
// ----------------------------------------------------------------------------
module sem_magnitude
  import sem_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        b_valid,
  input  sem_ctrl_t                   b_ctrl,
  input  logic signed [GRAD_W-1:0]    b_gx,
  input  logic signed [GRAD_W-1:0]    b_gy,
  output logic                        b_take,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [PIXEL_W-1:0]          magnitude,
  output logic signed [GRAD_W-1:0]    grad_x,
  output logic signed [GRAD_W-1:0]    grad_y,
  output logic                        saturated,
  output logic [COL_OUT_W-1:0]        center_column,
  output logic [ROW_W-1:0]            center_row,
  output logic                        last_of_frame
);

  logic [GRAD_W-1:0] ax, ay, sum;
  logic              sat;
  logic              fire_b;

  assign b_take = !out_valid || !out_stall;
  assign fire_b = b_valid && b_take;

  assign ax  = b_gx[GRAD_W-1] ? GRAD_W'(-b_gx) : GRAD_W'(b_gx);
  assign ay  = b_gy[GRAD_W-1] ? GRAD_W'(-b_gy) : GRAD_W'(b_gy);
  assign sum = ax + ay;
  assign sat = sum > GRAD_W'(255);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_take) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_b) begin
      magnitude     <= sat ? 8'd255 : sum[PIXEL_W-1:0];
      grad_x        <= b_gx;
      grad_y        <= b_gy;
      saturated     <= sat;
      center_column <= b_ctrl.col;
      center_row    <= b_ctrl.row;
      last_of_frame <= b_ctrl.last;
    end
  end

endmodule
